>>> hw/rtl/rcbr_pkg.sv
// ----------------------------------------------------------------------------
// rcbr_pkg
// shared widths, limits and the control bundle of the rod-cutting cell chain
// ----------------------------------------------------------------------------
package rcbr_pkg;

  // longest rod handled; the chain has one cell per length
  localparam int unsigned MaxLen  = 64;
  // length counter must also hold MaxLen + 1 (overflow marker)
  localparam int unsigned LenW    = $clog2(MaxLen + 2);
  localparam int unsigned PriceW  = 16;
  localparam int unsigned RevW    = 22;
  localparam int unsigned RodW    = 7;

  localparam logic [RevW-1:0] RevMax = {RevW{1'b1}};

  // broadcast from the control to every cell
  typedef struct packed {
    logic              load;   // shift revenues, write the new price
    logic [LenW-1:0]   len;    // length being solved
    logic [PriceW-1:0] price;  // price for that length
  } ctrl_t;

endpackage

>>> hw/rtl/rcbr_cell.sv
// ----------------------------------------------------------------------------
// rcbr_cell
// one cell: holds p[i] and r[len-i], folds its candidate into a passing max
// ----------------------------------------------------------------------------
module rcbr_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rcbr_pkg::LenW-1:0]    cell_idx_i,
  input  rcbr_pkg::ctrl_t              ctrl_i,
  input  logic [rcbr_pkg::RevW-1:0]    rev_i,
  output logic [rcbr_pkg::RevW-1:0]    rev_o,
  input  logic                         tok_i,
  input  logic [rcbr_pkg::RevW-1:0]    acc_i,
  output logic                         tok_o,
  output logic [rcbr_pkg::RevW-1:0]    acc_o
);

  logic [rcbr_pkg::PriceW-1:0] price_q;
  logic [rcbr_pkg::RevW-1:0]   rev_q;
  logic                        tok_q;
  logic [rcbr_pkg::RevW-1:0]   acc_q, acc_d;
  logic [rcbr_pkg::RevW:0]     sum;
  logic [rcbr_pkg::RevW-1:0]   cand;

  // candidate p[i] + r[len-i], saturated to the revenue width
  assign sum  = (rcbr_pkg::RevW+1)'(price_q) + (rcbr_pkg::RevW+1)'(rev_q);
  assign cand = sum[rcbr_pkg::RevW] ? rcbr_pkg::RevMax : sum[rcbr_pkg::RevW-1:0];

  always_comb begin
    acc_d = acc_i;
    if ((cell_idx_i <= ctrl_i.len) && (cand > acc_i)) begin
      acc_d = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rev_q <= rev_i;
      if (cell_idx_i == ctrl_i.len) begin
        price_q <= ctrl_i.price;
      end
    end
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign rev_o = rev_q;
  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

>>> hw/rtl/rod_cutting_best_revenue.sv
// ----------------------------------------------------------------------------
// rod_cutting_best_revenue
// best revenue for rods of growing length, one cell per length in a chain
// ----------------------------------------------------------------------------
// flow: one item at a time, the input reopens once the result is in the out reg;
//   the token walks the cell chain one cell per cycle; an overflow item skips it
// reset: rst_ni clears all control, next length returns to 1, no item pending;
//   price and revenue cells are not cleared, they are written before use
// ----------------------------------------------------------------------------
module rod_cutting_best_revenue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rcbr_pkg::PriceW-1:0]   price_i,
  input  logic                          first_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcbr_pkg::RevW-1:0]     best_revenue_o,
  output logic [rcbr_pkg::RodW-1:0]     rod_length_o,
  output logic                          overflow_o
);

  localparam int unsigned N = rcbr_pkg::MaxLen;

  // control state
  logic                        busy_q;        // item accepted, result not yet in out reg
  logic [rcbr_pkg::LenW-1:0]   next_len_q;
  logic                        load_q;        // cells shift and write this cycle
  logic                        run_q;         // token enters cell 1 next edge
  logic                        pend_q;        // result waiting for the out reg
  logic                        out_valid_q;

  // payload
  logic [rcbr_pkg::LenW-1:0]   len_q;
  logic [rcbr_pkg::PriceW-1:0] price_q;
  logic [rcbr_pkg::RevW-1:0]   last_rev_q;    // r[len-1] of the current problem
  logic [rcbr_pkg::RevW-1:0]   pend_rev_q;
  logic [rcbr_pkg::RodW-1:0]   pend_len_q;
  logic                        pend_ovf_q;
  logic [rcbr_pkg::RevW-1:0]   out_rev_q;
  logic [rcbr_pkg::RodW-1:0]   out_len_q;
  logic                        out_ovf_q;

  logic                        in_fire;
  logic [rcbr_pkg::LenW-1:0]   cur_len;
  logic                        cur_ovf;
  logic                        move_out;
  rcbr_pkg::ctrl_t             ctrl;

  // chain wiring, index 0 is the feed into cell 1
  logic [rcbr_pkg::RevW-1:0]   rev_w [N+1];
  logic [rcbr_pkg::RevW-1:0]   acc_w [N+1];
  logic                        tok_w [N+1];
  logic                        tok_last;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // length of the incoming item, first restarts the problem
  assign cur_len = first_i ? rcbr_pkg::LenW'(1) : next_len_q;
  assign cur_ovf = (cur_len > rcbr_pkg::LenW'(N));

  assign ctrl.load  = load_q;
  assign ctrl.len   = len_q;
  assign ctrl.price = price_q;

  // r[0] = 0 shifts in for length 1, else the previous length's revenue
  assign rev_w[0] = (len_q == rcbr_pkg::LenW'(1)) ? '0 : last_rev_q;
  assign acc_w[0] = '0;
  assign tok_w[0] = run_q;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rcbr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (rcbr_pkg::LenW'(g + 1)),
      .ctrl_i     (ctrl),
      .rev_i      (rev_w[g]),
      .rev_o      (rev_w[g+1]),
      .tok_i      (tok_w[g]),
      .acc_i      (acc_w[g]),
      .tok_o      (tok_w[g+1]),
      .acc_o      (acc_w[g+1])
    );
  end

  assign tok_last = tok_w[N];

  // pending result moves into the out reg once that is free
  assign move_out = pend_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      next_len_q  <= rcbr_pkg::LenW'(1);
      load_q      <= 1'b0;
      run_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      load_q <= 1'b0;
      run_q  <= load_q;

      if (in_fire) begin
        busy_q <= 1'b1;
        if (cur_ovf) begin
          // stays at the overflow marker until a first item
          next_len_q <= rcbr_pkg::LenW'(N + 1);
          pend_q     <= 1'b1;
        end else begin
          next_len_q <= cur_len + rcbr_pkg::LenW'(1);
          load_q     <= 1'b1;
        end
      end

      if (tok_last) begin
        pend_q <= 1'b1;
      end

      if (move_out) begin
        pend_q      <= 1'b0;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      len_q   <= cur_len;
      price_q <= price_i;
      if (cur_ovf) begin
        pend_rev_q <= '0;
        pend_len_q <= '0;
        pend_ovf_q <= 1'b1;
      end
    end
    if (tok_last) begin
      last_rev_q <= acc_w[N];
      pend_rev_q <= acc_w[N];
      pend_len_q <= rcbr_pkg::RodW'(len_q);
      pend_ovf_q <= 1'b0;
    end
    if (move_out) begin
      out_rev_q <= pend_rev_q;
      out_len_q <= pend_len_q;
      out_ovf_q <= pend_ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_revenue_o = out_rev_q;
  assign rod_length_o   = out_len_q;
  assign overflow_o     = out_ovf_q;

  // at most one item is anywhere in the control pipeline
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({load_q, run_q, tok_last, pend_q}))
    else $error("more than one item in flight");

  // any work in progress keeps the input closed
  a_busy_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_q || run_q || tok_last || pend_q) |-> busy_q)
    else $error("work in progress while input open");

  // a loaded item starts its token in the next cycle
  a_load_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q |=> run_q)
    else $error("token not started after load");

  // overflow results carry zero revenue and length
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (best_revenue_o == '0 && rod_length_o == '0))
    else $error("overflow result with nonzero payload");

endmodule

>>> tb/sv/rcbr_test_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcbr_test_pkg
// tracks rod-cutting prices per problem and predicts the best-revenue results
// ----------------------------------------------------------------------------
package rcbr_test_pkg;

  import rcbr_pkg::*;

  typedef struct {
    logic [RevW-1:0] revenue;
    logic [RodW-1:0] rod_len;
    logic            ovf;
  } cut_result_t;

  class revenue_scoreboard;

    // index 0 unused, lengths run 1..MaxLen
    bit [PriceW-1:0] price_tab   [MaxLen+1];
    bit [RevW-1:0]   revenue_tab [MaxLen+1];
    int unsigned     next_len;
    cut_result_t     expected_q [$];
    int unsigned     error_count;

    function new();
      next_len    = 1;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // best split of a rod of length len, using this problem's prices only
    function bit [RevW-1:0] best_cut(int unsigned len);
      int unsigned best;
      int unsigned rest;
      int unsigned sum;
      best = 0;
      for (int unsigned i = 1; i <= len; i++) begin
        rest = (i == len) ? 0 : revenue_tab[len-i];
        sum  = price_tab[i] + rest;
        if (sum > RevMax) sum = RevMax;
        if (sum > best) best = sum;
      end
      return best[RevW-1:0];
    endfunction

    // accepted item: advance the length and queue the revenue it yields
    function void note_price(bit [PriceW-1:0] price, bit first);
      cut_result_t exp_r;
      int unsigned len;
      if (first) next_len = 1;
      len = next_len;
      if (len > MaxLen) begin
        next_len      = MaxLen + 1;
        exp_r.revenue = '0;
        exp_r.rod_len = '0;
        exp_r.ovf     = 1'b1;
      end else begin
        price_tab[len]   = price;
        revenue_tab[len] = best_cut(len);
        next_len         = len + 1;
        exp_r.revenue    = revenue_tab[len];
        exp_r.rod_len    = len[RodW-1:0];
        exp_r.ovf        = 1'b0;
      end
      expected_q.push_back(exp_r);
    endfunction

    function void check_result(logic [RevW-1:0] revenue, logic [RodW-1:0] rod_len,
                               logic ovf);
      cut_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: best_revenue %0d, rod_length %0d, overflow %0b",
               revenue, rod_len, ovf);
        error_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (revenue !== exp_r.revenue) begin
        $error("best_revenue: expected %0d, got %0d", exp_r.revenue, revenue);
        error_count++;
      end
      if (rod_len !== exp_r.rod_len) begin
        $error("rod_length: expected %0d, got %0d", exp_r.rod_len, rod_len);
        error_count++;
      end
      if (ovf !== exp_r.ovf) begin
        $error("overflow: expected %0b, got %0b", exp_r.ovf, ovf);
        error_count++;
      end
    endfunction

  endclass

endpackage

>>> tb/sv/rod_cutting_best_revenue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rod_cutting_best_revenue_test
// drives price sequences into the rod-cutting block and checks every revenue
// ----------------------------------------------------------------------------
// a short directed run covers restarts and price extremes, then random
// problems of mostly short lengths, some full-length and some running past the
// longest rod; the sender works in bursts, the receiver stalls on its own
// pattern, with one long receiver hold-off and one sender drain pause
// ----------------------------------------------------------------------------
module rod_cutting_best_revenue_test;

  import rcbr_pkg::*;
  import rcbr_test_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned RandItems   = 1050;
  localparam int unsigned HoldAtItem  = 400;   // long receiver hold-off starts here
  localparam int unsigned HoldCycles  = 1500;
  localparam int unsigned DrainAtItem = 700;   // sender waits for all results here
  localparam int unsigned CycleLimit  = 3000000;

  typedef enum int unsigned {
    PriceFull,
    PriceLow,
    PriceRising,
    PriceMax
  } price_style_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [PriceW-1:0] price_i     = '0;
  logic              first_i     = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [RevW-1:0]   best_revenue_o;
  logic [RodW-1:0]   rod_length_o;
  logic              overflow_o;

  revenue_scoreboard sb;
  int unsigned       items_in   = 0;
  int unsigned       burst_left = 0;
  int unsigned       cycle_cnt  = 0;

  rod_cutting_best_revenue i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .price_i,
    .first_i,
    .out_valid_o,
    .out_ready_i,
    .best_revenue_o,
    .rod_length_o,
    .overflow_o
  );

  always #ClkHalf clk_i = ~clk_i;

  // watchdog, a correct run ends far below this
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(best_revenue_o, rod_length_o, overflow_o);
    end
  end

  // receiver stall pattern: runs of always-ready, coin-flip and mostly-stalled,
  // plus one long hold-off once the sender is well under way
  initial begin
    int unsigned mode;
    int unsigned run_left;
    int unsigned hold_left;
    bit          hold_done;
    logic        rdy;
    run_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode      = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && items_in >= HoldAtItem) begin
        // sender keeps offering, the block fills and must stall its input
        hold_done = 1'b1;
        hold_left = HoldCycles;
        rdy       = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(20, 300);
        end
        run_left--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  // offer one item, holding valid and payload until accepted; a new burst
  // may begin with a random gap so gaps land on every phase of the work
  task automatic send_item(input logic [PriceW-1:0] price, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 9) < 4) gap = 0;
      else if ($urandom_range(0, 9) < 7) gap = $urandom_range(1, 8);
      else gap = $urandom_range(9, 150);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    price_i    <= price;
    first_i    <= first;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_price(price, first);
    items_in++;
  endtask

  // one problem of n_items lengths; a problem not marked fresh continues the
  // previous one without the first flag
  task automatic run_problem(input int unsigned n_items, input price_style_e style,
                             input bit fresh);
    logic [PriceW-1:0] p;
    for (int unsigned k = 1; k <= n_items; k++) begin
      case (style)
        PriceFull:   p = PriceW'($urandom_range(0, 65535));
        PriceLow:    p = PriceW'($urandom_range(0, 255));
        PriceRising: p = PriceW'(k * $urandom_range(50, 900) + $urandom_range(0, 99));
        default:     p = '1;
      endcase
      send_item(p, fresh && (k == 1));
    end
  endtask

  initial begin
    int unsigned  n_len;
    int unsigned  pick;
    price_style_e style;
    bit           drained;
    sb      = new();
    drained = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: length 1 straight after reset without the first flag
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0001, 1'b0);
    // back-to-back restarts
    send_item(16'h5555, 1'b1);
    send_item(16'hAAAA, 1'b1);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h0000, 1'b0);
    // max price, then zero prices so cutting into pieces wins
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'hFFFF, 1'b0);

    // full length at max price, then past the longest rod: widest revenue
    // and the overflow case
    run_problem(MaxLen + 3, PriceMax, 1'b1);
    // full length with random prices
    run_problem(MaxLen, PriceFull, 1'b1);

    // random problems, mostly short
    while (items_in < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) n_len = $urandom_range(1, 16);
      else if (pick < 85) n_len = MaxLen;
      else n_len = $urandom_range(MaxLen + 1, MaxLen + 6);
      style = price_style_e'($urandom_range(0, 3));
      // a few continue the previous problem, often running into overflow
      run_problem(n_len, style, $urandom_range(0, 9) != 0);

      // once: let the block drain completely before going on
      if (!drained && items_in >= DrainAtItem) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
    end

    // wait for the last results, then a latency's worth for stray ones
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (MaxLen + 8) @(posedge clk_i);

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rcbr_pkg.sv
hw/rtl/rcbr_cell.sv
hw/rtl/rod_cutting_best_revenue.sv
tb/sv/rcbr_test_pkg.sv
tb/sv/rod_cutting_best_revenue_test.sv
